// ===== hw/rtl/i2cms_pkg.sv =====
// Shared types and codes of the I2C master transfer sequencer.
// No dependencies; used by i2cms_step and the top level.
package i2cms_pkg;

    // Host commands
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Bus status event codes
    localparam logic [3:0] EV_START      = 4'd0;
    localparam logic [3:0] EV_RESTART    = 4'd1;
    localparam logic [3:0] EV_ADDR_W_ACK = 4'd2;
    localparam logic [3:0] EV_DATA_W_ACK = 4'd3;
    localparam logic [3:0] EV_ADDR_R_ACK = 4'd4;
    localparam logic [3:0] EV_DATA_R_ACK = 4'd5;
    localparam logic [3:0] EV_DATA_R_NACK = 4'd6;
    localparam logic [3:0] EV_ARB_LOST   = 4'd7;
    localparam logic [3:0] EV_NACK       = 4'd8;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_NACK = 2'd1;
    localparam logic [1:0] ERR_BUS  = 2'd2;

    localparam logic [2:0] PTR_MAX = 3'd7;

    // Sequencer state
    typedef struct packed {
        logic [2:0] length;
        logic [2:0] ptr;
        logic       active;
        logic       success;
        logic [1:0] err;
    } seq_state_t;

    // Per-beat buffer access and bus control
    typedef struct packed {
        logic       wr_en;
        logic [2:0] wr_pos;
        logic [2:0] rd_pos;
        logic       tx_load;
        logic       rd_load;
        logic       clear_flag;
        logic       send_ack;
        logic       send_start;
        logic       send_stop;
    } step_ctrl_t;

endpackage

// ===== hw/rtl/i2c_master_transfer_sequencer.sv =====
// Top level of the I2C master transfer sequencer: state, message buffer, result register.
// Depends on i2cms_pkg and i2cms_step.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | command, index, data_in, length, event_req
//  out     | out_valid / out_ready| tx_byte, tx_valid, irq_enable, clear_flag,
//          |                      | send_ack, send_start, send_stop, busy_res,
//          |                      | done_ok, error_status, read_byte
//
// Each beat is decoded combinationally; its result appears in the result register
// on the next cycle, so one beat per cycle is sustained while out_ready is high.
// The buffer read for tx_byte / read_byte lands in the same register. in_ready
// drops only while a result is held with out_ready low. Reset clears the
// sequencer state and the result valid; buffer contents stay undefined until written.
module i2c_master_transfer_sequencer #(
    parameter int BUFFER_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [1:0] index,
    input  logic [7:0] data_in,
    input  logic [2:0] length,
    input  logic [3:0] event_req,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       tx_valid,
    output logic       irq_enable,
    output logic       clear_flag,
    output logic       send_ack,
    output logic       send_start,
    output logic       send_stop,
    output logic       busy_res,
    output logic       done_ok,
    output logic [1:0] error_status,
    output logic [7:0] read_byte
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    i2cms_pkg::seq_state_t state_reg;
    i2cms_pkg::seq_state_t state_next;
    i2cms_pkg::step_ctrl_t ctrl;

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [8:0]    wr_ext;
    logic [8:0]    rd_ext;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_in_range;
    logic          rd_in_range;
    logic          accept;

    logic       out_valid_reg;
    logic       tx_valid_reg;
    logic       tx_show_reg;
    logic       rd_show_reg;
    logic       clear_flag_reg;
    logic       send_ack_reg;
    logic       send_start_reg;
    logic       send_stop_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [1:0] err_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    i2cms_step u_step (
        .command    (command),
        .index      (index),
        .length     (length),
        .event_req  (event_req),
        .state      (state_reg),
        .state_next (state_next),
        .ctrl       (ctrl)
    );

    // Map buffer positions onto addresses and drop those beyond the buffer
    always_comb
    begin
        wr_ext      = 9'(ctrl.wr_pos);
        rd_ext      = 9'(ctrl.rd_pos);
        wr_addr     = wr_ext[AW-1:0];
        rd_addr     = rd_ext[AW-1:0];
        wr_in_range = wr_ext < 9'(BUFFER_DEPTH);
        rd_in_range = rd_ext < 9'(BUFFER_DEPTH);
    end

    // Write the message buffer and register its read data
    always_ff @(posedge clk)
    begin
        if (accept && ctrl.wr_en && wr_in_range)
        begin
            mem[wr_addr] <= data_in;
        end
        if (accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Advance the sequencer state on each accepted beat and track the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result fields; hold them while the result is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_valid_reg   <= ctrl.tx_load;
            tx_show_reg    <= ctrl.tx_load && rd_in_range;
            rd_show_reg    <= ctrl.rd_load && rd_in_range;
            clear_flag_reg <= ctrl.clear_flag;
            send_ack_reg   <= ctrl.send_ack;
            send_start_reg <= ctrl.send_start;
            send_stop_reg  <= ctrl.send_stop;
            busy_reg       <= state_next.active;
            done_reg       <= state_next.success;
            err_reg        <= state_next.err;
        end
    end

    // Drive the result beat
    assign out_valid    = out_valid_reg;
    assign tx_byte      = tx_show_reg ? rd_data_reg : 8'd0;
    assign read_byte    = rd_show_reg ? rd_data_reg : 8'd0;
    assign tx_valid     = tx_valid_reg;
    assign irq_enable   = busy_reg;
    assign busy_res     = busy_reg;
    assign clear_flag   = clear_flag_reg;
    assign send_ack     = send_ack_reg;
    assign send_start   = send_start_reg;
    assign send_stop    = send_stop_reg;
    assign done_ok      = done_reg;
    assign error_status = err_reg;

endmodule

// ===== hw/rtl/i2cms_step.sv =====
// Next-state and control decode for one command beat of the sequencer.
// Depends on i2cms_pkg.
module i2cms_step (
    input  logic [1:0]             command,
    input  logic [1:0]             index,
    input  logic [2:0]             length,
    input  logic [3:0]             event_req,
    input  i2cms_pkg::seq_state_t  state,
    output i2cms_pkg::seq_state_t  state_next,
    output i2cms_pkg::step_ctrl_t  ctrl
);

    logic [2:0] ptr_base;
    logic [2:0] ptr_inc;
    logic [2:0] ptr_rd_inc;

    // Pointer used by send events: start and restart rewind it
    always_comb
    begin
        ptr_base   = (event_req == i2cms_pkg::EV_START || event_req == i2cms_pkg::EV_RESTART)
                     ? 3'd0 : state.ptr;
        ptr_inc    = (ptr_base == i2cms_pkg::PTR_MAX) ? ptr_base : ptr_base + 3'd1;
        ptr_rd_inc = (state.ptr == i2cms_pkg::PTR_MAX) ? state.ptr : state.ptr + 3'd1;
    end

    // Decode the command and bus event
    always_comb
    begin
        state_next = state;
        ctrl       = '0;
        ctrl.wr_pos = {1'b0, index};
        ctrl.rd_pos = {1'b0, index};
        unique case (i2cms_pkg::cmd_t'(command))
            i2cms_pkg::CMD_LOAD:
            begin
                ctrl.wr_en = !state.active;
            end
            i2cms_pkg::CMD_START:
            begin
                if (!state.active)
                begin
                    state_next.length  = length;
                    state_next.success = 1'b0;
                    state_next.err     = i2cms_pkg::ERR_NONE;
                    state_next.active  = 1'b1;
                    ctrl.clear_flag    = 1'b1;
                    ctrl.send_start    = 1'b1;
                end
            end
            i2cms_pkg::CMD_READ:
            begin
                ctrl.rd_load = !state.active && state.success;
            end
            i2cms_pkg::CMD_EVENT:
            begin
                if (state.active)
                begin
                    case (event_req)
                        i2cms_pkg::EV_START, i2cms_pkg::EV_RESTART,
                        i2cms_pkg::EV_ADDR_W_ACK, i2cms_pkg::EV_DATA_W_ACK:
                        begin
                            state_next.ptr  = ptr_base;
                            ctrl.clear_flag = 1'b1;
                            if (ptr_base < state.length)
                            begin
                                ctrl.rd_pos    = ptr_base;
                                ctrl.tx_load   = 1'b1;
                                state_next.ptr = ptr_inc;
                            end
                            else
                            begin
                                state_next.success = 1'b1;
                                state_next.active  = 1'b0;
                                ctrl.send_stop     = 1'b1;
                            end
                        end
                        i2cms_pkg::EV_ADDR_R_ACK:
                        begin
                            ctrl.clear_flag = 1'b1;
                            ctrl.send_ack   = ({1'b0, state.ptr} + 4'd1) < {1'b0, state.length};
                        end
                        i2cms_pkg::EV_DATA_R_ACK:
                        begin
                            ctrl.wr_en      = 1'b1;
                            ctrl.wr_pos     = state.ptr;
                            state_next.ptr  = ptr_rd_inc;
                            ctrl.clear_flag = 1'b1;
                            ctrl.send_ack   = ({1'b0, ptr_rd_inc} + 4'd1) < {1'b0, state.length};
                        end
                        i2cms_pkg::EV_DATA_R_NACK:
                        begin
                            ctrl.wr_en         = 1'b1;
                            ctrl.wr_pos        = state.ptr;
                            state_next.success = 1'b1;
                            state_next.active  = 1'b0;
                            ctrl.clear_flag    = 1'b1;
                            ctrl.send_stop     = 1'b1;
                        end
                        i2cms_pkg::EV_ARB_LOST:
                        begin
                            ctrl.clear_flag = 1'b1;
                            ctrl.send_start = 1'b1;
                        end
                        i2cms_pkg::EV_NACK:
                        begin
                            state_next.err    = i2cms_pkg::ERR_NACK;
                            state_next.active = 1'b0;
                        end
                        default:
                        begin
                            // bus error and unknown codes
                            state_next.err    = i2cms_pkg::ERR_BUS;
                            state_next.active = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ===== hw/rtl/i2cms_checker.sv =====
// Port-level checks of the I2C master transfer sequencer, bound to its top level.
// Depends only on the top level's ports.
module i2cms_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] tx_byte,
    input logic       tx_valid,
    input logic       send_start,
    input logic       send_stop,
    input logic       busy_res,
    input logic       done_ok,
    input logic [7:0] read_byte
);

    // A stop ends the transfer successfully
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_stop |-> !busy_res && done_ok && !send_start)
    else $error("stop beat without a completed transfer");

    // A byte handed to the bus keeps the transfer running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |-> busy_res && !send_stop)
    else $error("tx byte outside an active transfer");

    // Buffer reads return data only after a good transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_byte != 8'd0) |-> done_ok && !busy_res && !tx_valid)
    else $error("read data returned without a completed transfer");

    // Tx byte is zero unless it is being loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0)
    else $error("tx byte nonzero without tx_valid");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(read_byte))
    else $error("result changed while stalled");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .tx_valid   (tx_valid),
    .send_start (send_start),
    .send_stop  (send_stop),
    .busy_res   (busy_res),
    .done_ok    (done_ok),
    .read_byte  (read_byte)
);

// ===== tb/i2c_master_transfer_sequencer_test.sv =====
// Testbench for the I2C master transfer sequencer: directed and random beats,
// random stalls on both channels, and a scoreboard that predicts every result beat.
// Depends on i2cms_pkg and the i2c_master_transfer_sequencer top level.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_test;

    localparam int         DEPTH        = 4;
    localparam int         ITEMS        = 700;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         HOLDOFF      = 300;
    localparam logic [3:0] EV_BUS_ERROR = 4'd9;

    typedef struct packed {
        i2cms_pkg::cmd_t cmd;
        logic [1:0]      idx;
        logic [7:0]      data;
        logic [2:0]      len;
        logic [3:0]      ev;
    } beat_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq_enable;
        logic       clear_flag;
        logic       send_ack;
        logic       send_start;
        logic       send_stop;
        logic       busy_res;
        logic       done_ok;
        logic [1:0] error_status;
        logic [7:0] read_byte;
    } status_t;

    // Scoreboard: tracks sequencer state and holds the status beats still due
    class transfer_scoreboard;
        logic [7:0] msg_buf [DEPTH];
        logic [2:0] msg_len = '0;
        logic [2:0] ptr     = '0;
        logic       act     = 1'b0;
        logic       succ    = 1'b0;
        logic [1:0] err     = i2cms_pkg::ERR_NONE;
        status_t    status_q [$];
        int         failures   = 0;
        int         mismatches = 0;

        function int pending();
            return status_q.size();
        endfunction

        function string show(status_t s);
            return $sformatf({"tx=%h/%b irq=%b clr=%b ack=%b sta=%b sto=%b",
                              " busy=%b ok=%b err=%0d rd=%h"},
                s.tx_byte, s.tx_valid, s.irq_enable, s.clear_flag, s.send_ack,
                s.send_start, s.send_stop, s.busy_res, s.done_ok, s.error_status,
                s.read_byte);
        endfunction

        // Advance the sequencer state by one beat and return its status
        function status_t next_status(beat_t b);
            status_t s;
            s = '0;
            case (b.cmd)
                i2cms_pkg::CMD_LOAD:
                    if (!act)
                        msg_buf[b.idx] = b.data;
                i2cms_pkg::CMD_START:
                    if (!act)
                    begin
                        msg_len = b.len;
                        succ = 1'b0;
                        err = i2cms_pkg::ERR_NONE;
                        act = 1'b1;
                        s.clear_flag = 1'b1;
                        s.send_start = 1'b1;
                    end
                i2cms_pkg::CMD_READ:
                    if (!act && succ)
                        s.read_byte = msg_buf[b.idx];
                default:
                    if (act)
                    begin
                        case (b.ev)
                            i2cms_pkg::EV_START, i2cms_pkg::EV_RESTART,
                            i2cms_pkg::EV_ADDR_W_ACK, i2cms_pkg::EV_DATA_W_ACK:
                            begin
                                if (b.ev == i2cms_pkg::EV_START ||
                                    b.ev == i2cms_pkg::EV_RESTART)
                                    ptr = '0;
                                if (ptr < msg_len)
                                begin
                                    s.tx_byte = (ptr < DEPTH) ? msg_buf[ptr[1:0]] : 8'h00;
                                    s.tx_valid = 1'b1;
                                    if (ptr != i2cms_pkg::PTR_MAX)
                                        ptr = ptr + 3'd1;
                                end
                                else
                                begin
                                    succ = 1'b1;
                                    act = 1'b0;
                                    s.send_stop = 1'b1;
                                end
                                s.clear_flag = 1'b1;
                            end
                            i2cms_pkg::EV_ADDR_R_ACK, i2cms_pkg::EV_DATA_R_ACK:
                            begin
                                if (b.ev == i2cms_pkg::EV_DATA_R_ACK)
                                begin
                                    if (ptr < DEPTH)
                                        msg_buf[ptr[1:0]] = b.data;
                                    if (ptr != i2cms_pkg::PTR_MAX)
                                        ptr = ptr + 3'd1;
                                end
                                s.clear_flag = 1'b1;
                                if ({1'b0, ptr} + 4'd1 < {1'b0, msg_len})
                                    s.send_ack = 1'b1;
                            end
                            i2cms_pkg::EV_DATA_R_NACK:
                            begin
                                if (ptr < DEPTH)
                                    msg_buf[ptr[1:0]] = b.data;
                                succ = 1'b1;
                                act = 1'b0;
                                s.clear_flag = 1'b1;
                                s.send_stop = 1'b1;
                            end
                            i2cms_pkg::EV_ARB_LOST:
                            begin
                                s.clear_flag = 1'b1;
                                s.send_start = 1'b1;
                            end
                            i2cms_pkg::EV_NACK:
                            begin
                                err = i2cms_pkg::ERR_NACK;
                                act = 1'b0;
                            end
                            // bus error and every unknown code
                            default:
                            begin
                                err = i2cms_pkg::ERR_BUS;
                                act = 1'b0;
                            end
                        endcase
                    end
            endcase
            s.irq_enable = act;
            s.busy_res = act;
            s.done_ok = succ;
            s.error_status = err;
            return s;
        endfunction

        function void note_beat(beat_t b);
            status_q.push_back(next_status(b));
        endfunction

        function void check_result(status_t got);
            status_t want;
            if (status_q.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result beat: %s", show(got));
                mismatches++;
                return;
            end
            want = status_q.pop_front();
            if (got !== want)
            begin
                failures++;
                if (mismatches < 10)
                    $display("mismatch: expected %s\n          actual   %s",
                             show(want), show(got));
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [1:0] index;
    logic [7:0] data_in;
    logic [2:0] length;
    logic [3:0] event_req;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       irq_enable;
    logic       clear_flag;
    logic       send_ack;
    logic       send_start;
    logic       send_stop;
    logic       busy_res;
    logic       done_ok;
    logic [1:0] error_status;
    logic [7:0] read_byte;

    transfer_scoreboard sb = new();
    bit steady = 1'b0;
    int beats_sent = 0;
    int results_seen = 0;

    i2c_master_transfer_sequencer #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .index(index),
        .data_in(data_in),
        .length(length),
        .event_req(event_req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tx_byte(tx_byte),
        .tx_valid(tx_valid),
        .irq_enable(irq_enable),
        .clear_flag(clear_flag),
        .send_ack(send_ack),
        .send_start(send_start),
        .send_stop(send_stop),
        .busy_res(busy_res),
        .done_ok(done_ok),
        .error_status(error_status),
        .read_byte(read_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function int draw_gap();
        return steady ? 0 : $urandom_range(0, 18);
    endfunction

    function beat_t mk(i2cms_pkg::cmd_t c, logic [1:0] i, logic [7:0] d, logic [2:0] l,
                       logic [3:0] e);
        beat_t b;
        b.cmd = c;
        b.idx = i;
        b.data = d;
        b.len = l;
        b.ev = e;
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(beat_t b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command <= b.cmd;
        index <= b.idx;
        data_in <= b.data;
        length <= b.len;
        event_req <= b.ev;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(b);
        beats_sent++;
    endtask

    // Bus event beat; unused fields carry random junk
    task automatic send_event(logic [3:0] ev);
        send_beat(mk(i2cms_pkg::CMD_EVENT, 2'($urandom), 8'($urandom), 3'($urandom), ev));
    endtask

    task automatic send_noise();
        send_beat(mk(i2cms_pkg::cmd_t'($urandom_range(0, 3)), 2'($urandom), 8'($urandom),
                     3'($urandom), 4'($urandom)));
    endtask

    // Stop offering and wait for every due status beat
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One mostly well-formed transfer with occasional noise, arbitration loss or abort
    task automatic run_transfer(bit rd);
        int len;
        int n_ev;
        int k;
        int cut;
        int lost_at;
        int r;
        logic [3:0] ev;
        r = $urandom_range(0, 9);
        if (r < 8)
            len = $urandom_range(1, 4);
        else if (r == 8)
            len = 0;
        else
            len = $urandom_range(5, 7);
        send_beat(mk(i2cms_pkg::CMD_LOAD, 2'd0, {7'($urandom), rd}, 3'($urandom),
                     4'($urandom)));
        for (int i = 1; i < DEPTH; i++)
            if ($urandom_range(0, 1))
                send_beat(mk(i2cms_pkg::CMD_LOAD, 2'(i), 8'($urandom), 3'($urandom),
                             4'($urandom)));
        send_beat(mk(i2cms_pkg::CMD_START, 2'($urandom), 8'($urandom), 3'(len),
                     4'($urandom)));
        if (rd)
            n_ev = (len >= 2) ? len + 1 : 3;
        else
            n_ev = len + 1;
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n_ev - 1) : -1;
        lost_at = ($urandom_range(0, 14) == 0) ? $urandom_range(1, n_ev - 1) : -1;
        k = 0;
        while (k < n_ev)
        begin
            if ($urandom_range(0, 14) == 0)
                send_noise();
            if (k == cut)
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    send_event(i2cms_pkg::EV_NACK);
                else if (r == 1)
                    send_event(EV_BUS_ERROR);
                else
                    send_event(4'($urandom_range(10, 15)));
                break;
            end
            else if (k == lost_at)
            begin
                // lost arbitration: restart the message from the top
                send_event(i2cms_pkg::EV_ARB_LOST);
                lost_at = -1;
                k = 0;
            end
            else
            begin
                if (k == 0)
                    ev = $urandom_range(0, 3) == 0 ? i2cms_pkg::EV_RESTART
                                                   : i2cms_pkg::EV_START;
                else if (!rd)
                    ev = (k == 1) ? i2cms_pkg::EV_ADDR_W_ACK : i2cms_pkg::EV_DATA_W_ACK;
                else if (k == 1)
                    ev = i2cms_pkg::EV_ADDR_R_ACK;
                else if (k == n_ev - 1)
                    ev = i2cms_pkg::EV_DATA_R_NACK;
                else
                    ev = i2cms_pkg::EV_DATA_R_ACK;
                send_event(ev);
                k++;
            end
        end
        // read back part of the buffer
        if ($urandom_range(0, 1))
            for (int i = $urandom_range(1, 4); i > 0; i--)
                send_beat(mk(i2cms_pkg::CMD_READ, 2'($urandom), 8'($urandom), 3'($urandom),
                             4'($urandom)));
    endtask

    // Result side: random stalls, one long hold-off, check every accepted beat
    initial
    begin
        int gap;
        bit held;
        status_t got;
        held = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 200)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLDOFF) @(posedge clk);
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.tx_byte = tx_byte;
            got.tx_valid = tx_valid;
            got.irq_enable = irq_enable;
            got.clear_flag = clear_flag;
            got.send_ack = send_ack;
            got.send_start = send_start;
            got.send_stop = send_stop;
            got.busy_res = busy_res;
            got.done_ok = done_ok;
            got.error_status = error_status;
            got.read_byte = read_byte;
            sb.check_result(got);
            results_seen++;
        end
    end

    // Watchdog: end the run after too many cycles without a handshake
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_master_transfer_sequencer_test NOT OK");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit paused;
        paused = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        out_ready <= 1'b0;
        command <= i2cms_pkg::CMD_LOAD;
        index <= '0;
        data_in <= '0;
        length <= '0;
        event_req <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every buffer entry first so no unwritten entry is ever read
        send_beat(mk(i2cms_pkg::CMD_LOAD, 2'd0, 8'h00, 3'd7, 4'hF));
        send_beat(mk(i2cms_pkg::CMD_LOAD, 2'd1, 8'hFF, 3'd0, 4'h0));
        send_beat(mk(i2cms_pkg::CMD_LOAD, 2'd2, 8'hA5, 3'd5, 4'h9));
        send_beat(mk(i2cms_pkg::CMD_LOAD, 2'd3, 8'h5A, 3'd2, 4'h6));
        // read before any transfer succeeded, event while idle
        send_beat(mk(i2cms_pkg::CMD_READ, 2'd2, 8'h00, 3'd1, 4'h0));
        send_event(i2cms_pkg::EV_START);
        // clean two-byte write
        send_beat(mk(i2cms_pkg::CMD_START, 2'd0, 8'h00, 3'd2, 4'h0));
        send_event(i2cms_pkg::EV_START);
        send_event(i2cms_pkg::EV_ADDR_W_ACK);
        send_event(i2cms_pkg::EV_DATA_W_ACK);
        send_beat(mk(i2cms_pkg::CMD_READ, 2'd3, 8'h00, 3'd0, 4'h0));
        // busy refusal, restart, arbitration loss, then NACK
        send_beat(mk(i2cms_pkg::CMD_START, 2'd0, 8'h00, 3'd4, 4'h0));
        send_beat(mk(i2cms_pkg::CMD_LOAD, 2'd0, 8'h77, 3'd0, 4'h0));
        send_beat(mk(i2cms_pkg::CMD_READ, 2'd0, 8'h00, 3'd0, 4'h0));
        send_beat(mk(i2cms_pkg::CMD_START, 2'd0, 8'h00, 3'd1, 4'h0));
        send_event(i2cms_pkg::EV_RESTART);
        send_event(i2cms_pkg::EV_ARB_LOST);
        send_event(i2cms_pkg::EV_NACK);
        send_beat(mk(i2cms_pkg::CMD_READ, 2'd1, 8'h00, 3'd0, 4'h0));
        // zero length: stop at once
        send_beat(mk(i2cms_pkg::CMD_START, 2'd0, 8'h00, 3'd0, 4'h0));
        send_event(i2cms_pkg::EV_START);
        // odd length read ending in a NACK store
        send_beat(mk(i2cms_pkg::CMD_START, 2'd0, 8'h00, 3'd7, 4'h0));
        send_event(i2cms_pkg::EV_ADDR_R_ACK);
        send_beat(mk(i2cms_pkg::CMD_EVENT, 2'd0, 8'h3C, 3'd0, i2cms_pkg::EV_DATA_R_NACK));
        // unknown event counts as bus error
        send_beat(mk(i2cms_pkg::CMD_START, 2'd0, 8'h00, 3'd3, 4'h0));
        send_event(4'hF);

        // random part
        while (beats_sent < ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (!paused && beats_sent > ITEMS / 2)
            begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(0, 4) == 0)
                for (int i = $urandom_range(1, 5); i > 0; i--)
                    send_noise();
            else
                run_transfer($urandom_range(0, 1));
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("i2c_master_transfer_sequencer_test OK");
        else
            $display("i2c_master_transfer_sequencer_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_step.sv
hw/rtl/i2c_master_transfer_sequencer.sv
hw/rtl/i2cms_checker.sv
tb/i2c_master_transfer_sequencer_test.sv
